// File: rtl/fpba_pkg.sv
// Shared types and codes for the fit-policy block allocator.
`timescale 1ns / 1ps

package fpba_pkg;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_NEXT  = 2'd3
    } policy_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic CFG_FIT_POLICY    = 1'b0;
    localparam logic CFG_BLOCKS_IN_USE = 1'b1;

    localparam int CFG_DATA_W = 5;

    typedef struct packed {
        logic    clr;
        logic    vld;
        policy_t policy;
    } sel_ctrl_t;

endpackage

// File: rtl/fpba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fpba_sel.sv
// Candidate selector that keeps the chosen block while capacities stream past.
`timescale 1ns / 1ps

module fpba_sel #(
    parameter int IDX_W  = 4,
    parameter int SIZE_W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fpba_pkg::sel_ctrl_t ctrl,
    input  logic [IDX_W-1:0]    cand_idx,
    input  logic [SIZE_W-1:0]   cand_cap,
    input  logic [SIZE_W-1:0]   req,
    output logic                found,
    output logic [IDX_W-1:0]    pick,
    output logic [SIZE_W-1:0]   best
);
    import fpba_pkg::*;

    logic              found_reg, found_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic [SIZE_W-1:0] best_reg, best_next;
    logic              fits;
    logic              take;

    always_comb
    begin
        fits = (cand_cap >= req);
        take = 1'b0;
        if (ctrl.vld && fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else
            begin
                case (ctrl.policy)
                    POL_BEST:  take = (cand_cap < best_reg);
                    POL_WORST: take = (cand_cap > best_reg);
                    default:   take = 1'b0;
                endcase
            end
        end
        found_next = found_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        if (ctrl.clr)
        begin
            found_next = 1'b0;
            pick_next  = '0;
            best_next  = '0;
        end
        else if (take)
        begin
            found_next = 1'b1;
            pick_next  = cand_idx;
            best_next  = cand_cap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        best_reg <= best_next;
    end

    assign found = found_reg;
    assign pick  = pick_reg;
    assign best  = best_reg;

endmodule

// File: rtl/fit_policy_block_allocator.sv
// Top level of the fit-policy block allocator: control, configuration and result register.
//
// The input channel (in_valid/in_ready) takes one beat per item. A load beat
// writes one block capacity into the capacity RAM in the cycle it is accepted,
// clears the next-fit pointer and gives no result; the next beat can follow in
// the next cycle. An allocate beat starts a scan that reads one capacity per
// cycle from the RAM over the blocks in use, then writes back the reduced
// capacity of the chosen block, if one fits. A write-back state and a done
// state follow the scan; the done state loads the result into the output
// register, which offers it on the output channel (out_valid/out_ready).
// The next beat can be accepted in the first cycle the result is offered;
// the block takes no new item while an allocate is in progress.
// The result sits in an output register, so a new item is accepted while a
// result waits. When the receiver stalls and a second result is ready, the
// block holds it and takes no input until the output register frees up.
// Configuration writes (cfg_we/cfg_addr/cfg_wdata) take effect at once; the user must make
// them only while the block is idle, which the block does not enforce. Reset clears all
// capacities to zero, the pointer to zero, selects first fit and sixteen blocks in use.
`timescale 1ns / 1ps

module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [4:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [3:0]  block_index,
    input  logic [15:0] amount,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        granted,
    output logic [3:0]  chosen_block,
    output logic [15:0] capacity_left
);
    import fpba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    policy_t           policy_reg;
    logic [4:0]        biu_reg;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [SIZE_WIDTH-1:0] amt_reg, amt_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rvalid_reg;
    logic [NUM_BLOCKS-1:0] valid_reg;

    logic              res_gnt_reg, res_gnt_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [SIZE_WIDTH-1:0] res_cap_reg, res_cap_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_gnt_reg;
    logic [3:0]        out_blk_reg;
    logic [15:0]       out_cap_reg;
    logic              out_load;

    logic [CNT_W-1:0]  n_act;
    logic [IDX_W-1:0]  k_start;
    logic [IDX_W:0]    k_inc;
    logic              accept;
    logic              issue;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SIZE_WIDTH-1:0] ram_wdata;
    logic [SIZE_WIDTH-1:0] ram_rdata;
    logic [SIZE_WIDTH-1:0] cand_cap;

    sel_ctrl_t         sel_ctrl;
    logic              sel_found;
    logic [IDX_W-1:0]  sel_pick;
    logic [SIZE_WIDTH-1:0] sel_best;

    fpba_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (NUM_BLOCKS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    assign cand_cap = rvalid_reg ? ram_rdata : '0;

    fpba_sel #(
        .IDX_W  (IDX_W),
        .SIZE_W (SIZE_WIDTH)
    ) u_sel (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (sel_ctrl),
        .cand_idx (rd_idx_reg),
        .cand_cap (cand_cap),
        .req      (amt_reg),
        .found    (sel_found),
        .pick     (sel_pick),
        .best     (sel_best)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            biu_reg    <= 5'd16;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_FIT_POLICY)
            begin
                policy_reg <= policy_t'(cfg_wdata[1:0]);
            end
            else if (cfg_addr == CFG_BLOCKS_IN_USE)
            begin
                biu_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        if (biu_reg == 5'd0)
        begin
            n_act = CNT_W'(1);
        end
        else if (32'(biu_reg) > NUM_BLOCKS)
        begin
            n_act = CNT_W'(NUM_BLOCKS);
        end
        else
        begin
            n_act = CNT_W'(biu_reg);
        end
        k_start = ((policy_reg == POL_NEXT) && (32'(ptr_reg) < 32'(n_act))) ? ptr_reg : '0;
        k_inc   = {1'b0, k_reg} + 1'b1;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign issue    = (state_reg == S_SCAN) && (left_reg != '0);
    assign out_load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        k_next         = k_reg;
        left_next      = left_reg;
        n_next         = n_reg;
        amt_next       = amt_reg;
        rd_pend_next   = issue;
        res_gnt_next   = res_gnt_reg;
        res_idx_next   = res_idx_reg;
        res_cap_next   = res_cap_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_waddr      = IDX_W'(block_index);
        ram_wdata      = SIZE_WIDTH'(amount);
        sel_ctrl.clr    = 1'b0;
        sel_ctrl.vld    = rd_pend_reg;
        sel_ctrl.policy = policy_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_LOAD)
                    begin
                        ram_we   = (32'(block_index) < NUM_BLOCKS);
                        ptr_next = '0;
                    end
                    else
                    begin
                        amt_next     = SIZE_WIDTH'(amount);
                        n_next       = n_act;
                        left_next    = n_act;
                        k_next       = k_start;
                        sel_ctrl.clr = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    left_next = left_reg - 1'b1;
                    if (32'(k_inc) >= 32'(n_reg))
                    begin
                        k_next = '0;
                    end
                    else
                    begin
                        k_next = k_inc[IDX_W-1:0];
                    end
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ram_waddr    = sel_pick;
                ram_wdata    = sel_best - amt_reg;
                ram_we       = sel_found;
                res_gnt_next = sel_found;
                res_idx_next = sel_found ? sel_pick : '0;
                res_cap_next = sel_found ? (sel_best - amt_reg) : '0;
                if (sel_found && (policy_reg == POL_NEXT))
                begin
                    ptr_next = sel_pick;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            left_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            left_reg      <= left_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        n_reg       <= n_next;
        amt_reg     <= amt_next;
        rd_idx_reg  <= k_reg;
        rvalid_reg  <= valid_reg[k_reg];
        res_gnt_reg <= res_gnt_next;
        res_idx_reg <= res_idx_next;
        res_cap_reg <= res_cap_next;
        if ((state_reg == S_DONE) && out_load)
        begin
            out_gnt_reg <= res_gnt_reg;
            out_blk_reg <= 4'(res_idx_reg);
            out_cap_reg <= 16'(res_cap_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted       = out_gnt_reg;
    assign chosen_block  = out_blk_reg;
    assign capacity_left = out_cap_reg;

    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_IDLE) || (state_reg == S_WRITE)))
        else $error("Capacity RAM written outside a load or write-back.");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (32'(k_reg) < 32'(n_reg)))
        else $error("Scan address beyond the blocks in use.");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_SCAN))
        else $error("Read data returned outside the scan.");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !granted) |-> ((chosen_block == 4'd0) && (capacity_left == 16'd0)))
        else $error("Refused request carries a block or capacity.");

endmodule

// File: tb/fit_policy_block_allocator_tb.sv
// Self-checking testbench for the fit-policy block allocator with a built-in capacity table model.
`timescale 1ns / 1ps

module fit_policy_block_allocator_tb;
    import fpba_pkg::*;

    localparam int NBLK          = 16;
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_STALL    = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic        op;
        logic [3:0]  idx;
        logic [15:0] amt;
    } block_cmd_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  blk;
        logic [15:0] left;
    } grant_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic                  cfg_addr    = CFG_FIT_POLICY;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  in_valid    = 1'b0;
    logic                  operation   = OP_LOAD;
    logic [3:0]            block_index = '0;
    logic [15:0]           amount      = '0;
    logic                  out_ready   = 1'b0;
    wire                   in_ready;
    wire                   out_valid;
    wire                   granted;
    wire  [3:0]            chosen_block;
    wire  [15:0]           capacity_left;

    block_cmd_t pending_cmds[$];
    grant_t     expected_grants[$];
    block_cmd_t offered_cmd;

    logic [15:0]           model_cap [NBLK];
    logic [3:0]            model_ptr    = '0;
    policy_t               model_policy = POL_FIRST;
    logic [CFG_DATA_W-1:0] model_blocks = 5'd16;
    logic [15:0]           last_cap     = '0;

    int send_idle_pct = 20;
    int recv_idle_pct = 88;
    logic stall_req  = 1'b0;
    logic stall_seen = 1'b0;
    int stall_left   = 0;

    int cycle_count = 0;
    int mismatches  = 0;
    int n_loads     = 0;
    int n_allocs    = 0;
    int n_grants    = 0;
    int n_results   = 0;
    int n_cfg       = 0;

    fit_policy_block_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .block_index  (block_index),
        .amount       (amount),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted      (granted),
        .chosen_block (chosen_block),
        .capacity_left(capacity_left)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < NBLK; i++)
        begin
            model_cap[i] = '0;
        end
    end

    function automatic int unsigned active_blocks();
        if (model_blocks == 0)
        begin
            return 1;
        end
        if (model_blocks > NBLK)
        begin
            return NBLK;
        end
        return model_blocks;
    endfunction

    // Applies one accepted beat to the capacity table and, for an allocation, queues the grant it must produce.
    function automatic void predict_grant(block_cmd_t c);
        int unsigned n;
        int unsigned k;
        int unsigned pick;
        logic        found;
        grant_t      g;
        n     = active_blocks();
        found = 1'b0;
        pick  = 0;
        if (c.op == OP_LOAD)
        begin
            model_cap[c.idx] = c.amt;
            model_ptr        = '0;
            n_loads++;
            return;
        end
        n_allocs++;
        if (model_policy == POL_NEXT)
        begin
            k = (model_ptr < n) ? model_ptr : 0;
            for (int s = 0; s < n; s++)
            begin
                if (model_cap[k] >= c.amt)
                begin
                    found = 1'b1;
                    pick  = k;
                    break;
                end
                k = (k + 1 >= n) ? 0 : k + 1;
            end
            if (found)
            begin
                model_ptr = pick[3:0];
            end
        end
        else
        begin
            for (int j = 0; j < n; j++)
            begin
                if (model_cap[j] >= c.amt)
                begin
                    if (!found)
                    begin
                        found = 1'b1;
                        pick  = j;
                        if (model_policy == POL_FIRST)
                        begin
                            break;
                        end
                    end
                    else if (model_policy == POL_BEST && model_cap[j] < model_cap[pick])
                    begin
                        pick = j;
                    end
                    else if (model_policy == POL_WORST && model_cap[j] > model_cap[pick])
                    begin
                        pick = j;
                    end
                end
            end
        end
        if (found)
        begin
            model_cap[pick] = model_cap[pick] - c.amt;
            g = '{granted: 1'b1, blk: pick[3:0], left: model_cap[pick]};
            n_grants++;
        end
        else
        begin
            g = '{granted: 1'b0, blk: 4'd0, left: 16'd0};
        end
        expected_grants.push_back(g);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_grant(offered_cmd);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_cmd = pending_cmds.pop_front();
                    in_valid    <= 1'b1;
                    operation   <= offered_cmd.op;
                    block_index <= offered_cmd.idx;
                    amount      <= offered_cmd.amt;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_req != stall_seen)
        begin
            stall_seen <= stall_req;
            stall_left <= LONG_STALL;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (expected_grants.size() == 0)
            begin
                $error("Result beat with no allocation pending: granted=%0d block=%0d left=%0d",
                       granted, chosen_block, capacity_left);
                mismatches++;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (granted !== want.granted)
                begin
                    $error("granted: expected %0d, got %0d", want.granted, granted);
                    mismatches++;
                end
                if (chosen_block !== want.blk)
                begin
                    $error("chosen_block: expected %0d, got %0d", want.blk, chosen_block);
                    mismatches++;
                end
                if (capacity_left !== want.left)
                begin
                    $error("capacity_left: expected %0d, got %0d", want.left, capacity_left);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_grants.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_load(input logic [3:0] i, input logic [15:0] a);
        pending_cmds.push_back('{op: OP_LOAD, idx: i, amt: a});
    endtask

    task automatic push_alloc(input logic [15:0] a);
        pending_cmds.push_back('{op: OP_ALLOC, idx: 4'($urandom), amt: a});
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_grants.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == CFG_FIT_POLICY)
        begin
            model_policy = policy_t'(data[1:0]);
        end
        else
        begin
            model_blocks = data;
        end
        n_cfg++;
    endtask

    function automatic logic [15:0] random_capacity();
        logic [15:0] v;
        case ($urandom_range(9))
            0:       v = 16'd0;
            1:       v = 16'hFFFF;
            2, 3:    v = 16'($urandom);
            4:       v = last_cap;
            default: v = 16'($urandom_range(1, 3000));
        endcase
        last_cap = v;
        return v;
    endfunction

    function automatic logic [15:0] random_request();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2:       return model_cap[$urandom_range(NBLK - 1)];
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 600));
        endcase
    endfunction

    // Opens with allocations so the carried-over next-fit pointer meets the new setting.
    task automatic queue_phase(input int count);
        int unsigned nb;
        nb = active_blocks();
        for (int k = 0; k < 4; k++)
        begin
            push_alloc(random_request());
        end
        for (int k = 0; k < nb; k++)
        begin
            push_load(k[3:0], random_capacity());
        end
        for (int k = 0; k < count - 4 - int'(nb); k++)
        begin
            if ($urandom_range(99) < 12)
            begin
                push_load(4'($urandom), random_capacity());
            end
            else
            begin
                push_alloc(random_request());
            end
        end
    endtask

    initial
    begin
        int blocks_plan[PHASES];
        blocks_plan = '{16, 1, 0, 31, 5, 16, 17, 9};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        push_alloc(16'd0);
        push_alloc(16'd1);
        push_load(4'd0, 16'hFFFF);
        push_load(4'd3, 16'd50);
        push_load(4'd5, 16'd100);
        push_load(4'd7, 16'd100);
        push_load(4'd10, 16'hAAAA);
        push_load(4'd6, 16'h5555);
        push_load(4'd15, 16'd1);
        push_alloc(16'hFFFF);
        push_alloc(16'd1);
        push_alloc(16'd0);
        wait_drained();
        write_reg(CFG_FIT_POLICY, CFG_DATA_W'(POL_BEST));
        push_alloc(16'd50);
        push_alloc(16'd1);
        push_alloc(16'd100);
        wait_drained();
        write_reg(CFG_FIT_POLICY, CFG_DATA_W'(POL_WORST));
        push_alloc(16'd10);
        push_alloc(16'h5555);
        wait_drained();
        write_reg(CFG_FIT_POLICY, CFG_DATA_W'(POL_NEXT));
        push_alloc(16'd20);
        push_alloc(16'd20);
        push_alloc(16'hFFFF);
        push_load(4'd2, 16'd30);
        push_alloc(16'd5);
        wait_drained();
        write_reg(CFG_BLOCKS_IN_USE, 5'd0);
        push_alloc(16'd1);
        wait_drained();
        write_reg(CFG_BLOCKS_IN_USE, 5'd31);
        push_alloc(16'd1);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            send_idle_pct = (p < 3) ? 20 : ((p < 6) ? 88 : 0);
            recv_idle_pct = (p < 3) ? 88 : ((p < 6) ? 20 : 0);
            write_reg(CFG_FIT_POLICY,
                      CFG_DATA_W'((p < 4) ? p : $urandom_range(3)));
            write_reg(CFG_BLOCKS_IN_USE, CFG_DATA_W'(blocks_plan[p]));
            queue_phase(PHASE_ITEMS);
            if (p == 6)
            begin
                // The receiver holds off while the sender keeps offering beats.
                @(posedge clk);
                stall_req <= ~stall_req;
            end
        end

        wait_drained();
        $display("Covered %0d loads and %0d allocations (%0d granted, %0d results checked),",
                 n_loads, n_allocs, n_grants, n_results);
        $display("with %0d register writes over all four policies and block counts 0 to 31.",
                 n_cfg);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/fpba_pkg.sv
rtl/fpba_ram.sv
rtl/fpba_sel.sv
rtl/fit_policy_block_allocator.sv
tb/fit_policy_block_allocator_tb.sv
